// File: hdl/ppem_pkg.sv
// shared constants and types for the pulse period energy meter
// register indexes, reset values, opcodes and the sequencer state type
// no dependencies
package ppem_pkg;

    localparam int DEF_PHASES  = 3;
    localparam int GAIN_REGS   = 3;
    localparam int WORD_W      = 32;
    localparam int CNT_W       = 8;
    localparam int TIME_W      = 16;
    localparam int SPAN_W      = 17;
    localparam int CFG_ADDR_W  = 3;
    localparam int OP_W        = 2;
    localparam int PHASE_W     = 2;
    localparam int OUT_FIELDS  = 3;
    localparam int DIV_CNT_W   = 5;

    localparam logic [CFG_ADDR_W-1:0] CFG_GAIN_0   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_GAIN_1   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_GAIN_2   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_STEP     = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_INTERVAL = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_LIMIT    = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAIN_SPAN = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] CFG_AUX_SPAN = 3'd7;

    localparam logic [WORD_W-1:0] RST_STEP     = 32'd1000;
    localparam logic [CNT_W-1:0]  RST_INTERVAL = 8'd10;
    localparam logic [CNT_W-1:0]  RST_LIMIT    = 8'd50;
    localparam logic [SPAN_W-1:0] RST_SPAN     = 17'h10000;

    localparam logic [OP_W-1:0] OP_MAIN_TICK = 2'd0;
    localparam logic [OP_W-1:0] OP_AUX_TICK  = 2'd1;
    localparam logic [OP_W-1:0] OP_CAPTURE   = 2'd2;

    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_CAP  = 9'b000000010,
        ST_ACC  = 9'b000000100,
        ST_DIV  = 9'b000001000,
        ST_ADD  = 9'b000010000,
        ST_CMP  = 9'b000100000,
        ST_NXT  = 9'b001000000,
        ST_AGE  = 9'b010000000,
        ST_OUT  = 9'b100000000
    } t_state;

endpackage

// File: hdl/pulse_period_energy_meter_core.sv
// pulse period energy meter: capture-based period measurement and energy counting
// one sequencer around a shared restoring divider, one quotient bit per cycle
// depends on ppem_pkg
//
// usage: input words arrive on s_axis (tuser holds opcode and phase, tdata the
// capture time); every accepted word gives one output word on m_axis holding
// all periods and energy counts after the word, plus the new-period flag.
// registers are written through i_cfg_we / i_cfg_addr / i_cfg_data; the user must
// write them only while idle, which the core itself does not enforce.
// a main tick with accumulation divides for each phase with a nonzero period
// through the single shared divider; a phase with a zero period skips the divide.
// s_axis_tready is high only while the sequencer is idle; one word is in work
// at a time and input ready rises again in the same cycle as output valid.
// the finished word sits in an output register, so a new input word can be
// taken while the receiver stalls; the following result waits for the output
// register to empty and holds the input off meanwhile.
// reset (synchronous, active low) clears all phase state and loads register
// defaults; output valid and input ready drop.
module pulse_period_energy_meter_core #(
    parameter int PHASES = ppem_pkg::DEF_PHASES
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [ppem_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  logic [ppem_pkg::WORD_W-1:0]          i_cfg_data,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // capture_time
    input  logic [15:0]                          s_axis_tdata,
    // opcode [1:0], phase [3:2]
    input  logic [3:0]                           s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // period_a, period_b, period_c, energy_a, energy_b, energy_c
    output logic [191:0]                         m_axis_tdata,
    // new_period
    output logic [0:0]                           m_axis_tuser
);

    localparam int IDX_W     = (PHASES > 1) ? $clog2(PHASES) : 1;
    localparam int MAIN_LAST = ((PHASES < 2) ? PHASES : 2) - 1;
    localparam int LAST      = PHASES - 1;
    localparam int W         = ppem_pkg::WORD_W;

    // configuration
    logic [W-1:0]                   r_gain [ppem_pkg::GAIN_REGS];
    logic [W-1:0]                   r_step;
    logic [ppem_pkg::CNT_W-1:0]     r_interval;
    logic [ppem_pkg::CNT_W-1:0]     r_limit;
    logic [ppem_pkg::SPAN_W-1:0]    r_main_span;
    logic [ppem_pkg::SPAN_W-1:0]    r_aux_span;

    // phase state
    logic [ppem_pkg::CNT_W-1:0]     r_ovf    [PHASES];
    logic [ppem_pkg::TIME_W-1:0]    r_start  [PHASES];
    logic                           r_valid  [PHASES];
    logic [W-1:0]                   r_period [PHASES];
    logic [W-1:0]                   r_resid  [PHASES];
    logic [W-1:0]                   r_energy [PHASES];
    logic [ppem_pkg::CNT_W-1:0]     r_tick;

    // sequencer and working registers
    ppem_pkg::t_state               r_state;
    logic [IDX_W-1:0]               r_idx;
    logic [ppem_pkg::OP_W-1:0]      r_op;
    logic [ppem_pkg::TIME_W-1:0]    r_cap;
    logic                           r_new;
    logic [W-1:0]                   r_rem;
    logic [W-1:0]                   r_quo;
    logic [ppem_pkg::DIV_CNT_W-1:0] r_cnt;

    // output register
    logic                           r_m_valid;
    logic [191:0]                   r_m_data;
    logic                           r_m_new;

    logic [W-1:0]                   w_gain;
    logic [ppem_pkg::SPAN_W-1:0]    w_span;
    logic [W-1:0]                   n_period;
    logic [W:0]                     w_trial;
    logic [W-1:0]                   n_sum;
    logic [191:0]                   w_out;
    logic                           w_accept;
    logic [ppem_pkg::OP_W-1:0]      w_op;
    logic [ppem_pkg::PHASE_W-1:0]   w_phase;
    logic                           w_slot_free;

    assign w_op        = s_axis_tuser[1:0];
    assign w_phase     = s_axis_tuser[3:2];
    assign w_accept    = s_axis_tvalid && s_axis_tready;
    assign w_slot_free = !r_m_valid || m_axis_tready;

    assign s_axis_tready = i_rst_n && (r_state == ppem_pkg::ST_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_new;

    always_comb begin
        w_gain = '0;
        for (int g = 0; g < ppem_pkg::GAIN_REGS; g++) begin
            if (32'(r_idx) == g) begin
                w_gain = r_gain[g];
            end
        end
    end

    // period = span * overflows - start + capture, modulo 2^32
    assign w_span   = (32'(r_idx) < 2) ? r_main_span : r_aux_span;
    assign n_period = W'(w_span) * W'(r_ovf[r_idx]) - W'(r_start[r_idx]) + W'(r_cap);

    // restoring divide step
    assign w_trial = {r_rem, r_quo[W-1]} - {1'b0, r_period[r_idx]};
    assign n_sum   = r_resid[r_idx] + r_quo;

    always_comb begin
        w_out = '0;
        for (int p = 0; p < ppem_pkg::OUT_FIELDS; p++) begin
            if (p < PHASES) begin
                w_out[p*W +: W]                          = r_period[(p < PHASES) ? p : 0];
                w_out[(p+ppem_pkg::OUT_FIELDS)*W +: W]   = r_energy[(p < PHASES) ? p : 0];
            end
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int g = 0; g < ppem_pkg::GAIN_REGS; g++) begin
                r_gain[g] <= '0;
            end
            r_step      <= ppem_pkg::RST_STEP;
            r_interval  <= ppem_pkg::RST_INTERVAL;
            r_limit     <= ppem_pkg::RST_LIMIT;
            r_main_span <= ppem_pkg::RST_SPAN;
            r_aux_span  <= ppem_pkg::RST_SPAN;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                ppem_pkg::CFG_GAIN_0:    r_gain[0]   <= i_cfg_data;
                ppem_pkg::CFG_GAIN_1:    r_gain[1]   <= i_cfg_data;
                ppem_pkg::CFG_GAIN_2:    r_gain[2]   <= i_cfg_data;
                ppem_pkg::CFG_STEP:      r_step      <= i_cfg_data;
                ppem_pkg::CFG_INTERVAL:  r_interval  <= i_cfg_data[ppem_pkg::CNT_W-1:0];
                ppem_pkg::CFG_LIMIT:     r_limit     <= i_cfg_data[ppem_pkg::CNT_W-1:0];
                ppem_pkg::CFG_MAIN_SPAN: r_main_span <= i_cfg_data[ppem_pkg::SPAN_W-1:0];
                ppem_pkg::CFG_AUX_SPAN:  r_aux_span  <= i_cfg_data[ppem_pkg::SPAN_W-1:0];
                default: ;
            endcase
        end
    end

    // working payload, no reset
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cap <= s_axis_tdata;
        end
        if (r_state == ppem_pkg::ST_ACC) begin
            r_rem <= '0;
            r_quo <= w_gain;
        end else if (r_state == ppem_pkg::ST_DIV) begin
            if (!w_trial[W]) begin
                r_rem <= w_trial[W-1:0];
                r_quo <= {r_quo[W-2:0], 1'b1};
            end else begin
                r_rem <= {r_rem[W-2:0], r_quo[W-1]};
                r_quo <= {r_quo[W-2:0], 1'b0};
            end
        end
        if (r_state == ppem_pkg::ST_OUT && w_slot_free) begin
            r_m_data <= w_out;
            r_m_new  <= r_new;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ppem_pkg::ST_IDLE;
            r_idx     <= '0;
            r_op      <= ppem_pkg::OP_MAIN_TICK;
            r_new     <= 1'b0;
            r_cnt     <= '0;
            r_m_valid <= 1'b0;
            r_tick    <= '0;
            for (int p = 0; p < PHASES; p++) begin
                r_ovf[p]    <= '0;
                r_start[p]  <= '0;
                r_valid[p]  <= 1'b0;
                r_period[p] <= '0;
                r_resid[p]  <= '0;
                r_energy[p] <= '0;
            end
        end else begin
            if (r_m_valid && m_axis_tready && (r_state != ppem_pkg::ST_OUT)) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                ppem_pkg::ST_IDLE: begin
                    if (w_accept) begin
                        r_op  <= w_op;
                        r_new <= 1'b0;
                        case (w_op)
                            ppem_pkg::OP_MAIN_TICK: begin
                                r_idx   <= '0;
                                r_state <= (r_tick > r_interval) ? ppem_pkg::ST_ACC
                                                                 : ppem_pkg::ST_AGE;
                            end
                            ppem_pkg::OP_AUX_TICK: begin
                                if (PHASES > 2) begin
                                    r_idx   <= IDX_W'(2);
                                    r_state <= ppem_pkg::ST_AGE;
                                end else begin
                                    r_idx   <= '0;
                                    r_state <= ppem_pkg::ST_OUT;
                                end
                            end
                            ppem_pkg::OP_CAPTURE: begin
                                if (32'(w_phase) < PHASES) begin
                                    r_idx   <= IDX_W'(w_phase);
                                    r_state <= ppem_pkg::ST_CAP;
                                end else begin
                                    r_idx   <= '0;
                                    r_state <= ppem_pkg::ST_OUT;
                                end
                            end
                            default: begin
                                r_idx   <= '0;
                                r_state <= ppem_pkg::ST_OUT;
                            end
                        endcase
                    end
                end
                ppem_pkg::ST_CAP: begin
                    if (r_valid[r_idx]) begin
                        r_period[r_idx] <= n_period;
                        r_new           <= 1'b1;
                    end
                    r_start[r_idx] <= r_cap;
                    r_ovf[r_idx]   <= '0;
                    r_valid[r_idx] <= 1'b1;
                    r_state        <= ppem_pkg::ST_OUT;
                end
                ppem_pkg::ST_ACC: begin
                    r_cnt   <= '1;
                    r_state <= (r_period[r_idx] != '0) ? ppem_pkg::ST_DIV : ppem_pkg::ST_NXT;
                end
                ppem_pkg::ST_DIV: begin
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_state <= ppem_pkg::ST_ADD;
                    end
                end
                ppem_pkg::ST_ADD: begin
                    r_resid[r_idx] <= n_sum;
                    r_state        <= ppem_pkg::ST_CMP;
                end
                ppem_pkg::ST_CMP: begin
                    if (r_resid[r_idx] >= r_step) begin
                        r_energy[r_idx] <= r_energy[r_idx] + 1'b1;
                        r_resid[r_idx]  <= r_resid[r_idx] - r_step;
                    end
                    r_state <= ppem_pkg::ST_NXT;
                end
                ppem_pkg::ST_NXT: begin
                    if (32'(r_idx) == LAST) begin
                        r_tick  <= '0;
                        r_idx   <= '0;
                        r_state <= ppem_pkg::ST_AGE;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= ppem_pkg::ST_ACC;
                    end
                end
                ppem_pkg::ST_AGE: begin
                    if (r_ovf[r_idx] < r_limit) begin
                        r_ovf[r_idx] <= r_ovf[r_idx] + 1'b1;
                    end else begin
                        r_period[r_idx] <= '0;
                        r_valid[r_idx]  <= 1'b0;
                    end
                    if (r_op == ppem_pkg::OP_MAIN_TICK) begin
                        if (32'(r_idx) == MAIN_LAST) begin
                            r_tick  <= r_tick + 1'b1;
                            r_state <= ppem_pkg::ST_OUT;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end else begin
                        if (32'(r_idx) == LAST) begin
                            r_state <= ppem_pkg::ST_OUT;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                ppem_pkg::ST_OUT: begin
                    if (w_slot_free) begin
                        r_m_valid <= 1'b1;
                        r_state   <= ppem_pkg::ST_IDLE;
                    end
                end
                default: r_state <= ppem_pkg::ST_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !s_axis_tready)
        else $error("input taken while a word is in work");

    a_divisor_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ppem_pkg::ST_DIV) |-> (r_period[r_idx] != '0))
        else $error("divide started with a zero period");

    a_div_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ppem_pkg::ST_DIV && r_cnt == '0) |=> (r_state == ppem_pkg::ST_ADD))
        else $error("divide did not finish after its last step");

    a_out_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ppem_pkg::ST_OUT && w_slot_free) |=> r_m_valid)
        else $error("finished word not presented");
`endif

endmodule

// File: sim/pulse_period_energy_meter_core_test.sv
// self-checking testbench for pulse_period_energy_meter_core: directed rows, then random
// words under six register settings, checked word by word against an in-bench predictor
// depends on ppem_pkg and the core rtl
module pulse_period_energy_meter_core_test;

    localparam logic [ppem_pkg::OP_W-1:0]    OP_UNUSED = 2'd3;
    localparam logic [ppem_pkg::PHASE_W-1:0] PHASE_OOR = 2'd3;
    localparam int LIMIT_CYCLES  = 1000000;
    localparam int SETTLE_CYCLES = 150;
    localparam int RAND_PER_SET  = 280;
    localparam int SETTING_SETS  = 6;
    localparam int HOLD_AT       = 1300;
    localparam int HOLD_CYCLES   = 3000;
    localparam int CALM_FROM     = 900;
    localparam int CALM_TO       = 1100;
    localparam int IDLE_PCT      = 11;
    localparam int MAX_REPORTS   = 10;

    typedef struct packed {
        logic            fresh;
        logic [5:0][31:0] fields;
    } t_meter_word;

    typedef struct packed {
        logic [ppem_pkg::OP_W-1:0]    op;
        logic [ppem_pkg::PHASE_W-1:0] ph;
        logic [15:0]        cap;
        logic               typed;
        logic [31:0]        pa;
        logic [31:0]        pb;
        logic [31:0]        pc;
        logic               fresh;
    } t_dir_row;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_cfg_we = 1'b0;
    logic [ppem_pkg::CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [ppem_pkg::WORD_W-1:0]     i_cfg_data = '0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [15:0]                     s_axis_tdata = '0;
    logic [3:0]                      s_axis_tuser = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [191:0]                    m_axis_tdata;
    logic [0:0]                      m_axis_tuser;

    pulse_period_energy_meter_core #(
        .PHASES(ppem_pkg::DEF_PHASES)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state and register copies
    logic [31:0] cfg_gain [3];
    logic [31:0] cfg_step;
    logic [7:0]  cfg_interval;
    logic [7:0]  cfg_limit;
    logic [16:0] cfg_main_span;
    logic [16:0] cfg_aux_span;
    logic [7:0]  ovf_cnt [3];
    logic [15:0] start_t [3];
    logic        armed [3];
    logic [31:0] period [3];
    logic [31:0] residue [3];
    logic [31:0] energy [3];
    logic [7:0]  tick_cnt;

    t_meter_word expected_meter_q [$];
    t_dir_row    dir_rows [$];
    t_meter_word want_word;
    string       field_names [6] = '{"period_a", "period_b", "period_c",
                                     "energy_a", "energy_b", "energy_c"};

    int  sent_words = 0;
    int  checked_words = 0;
    int  mismatch_cnt = 0;
    int  fresh_seen = 0;
    int  n_capture = 0;
    int  n_main = 0;
    int  n_aux = 0;
    int  n_ignored = 0;
    int  cycle_cnt = 0;
    int  hold_left = -1;
    wire quiet = (sent_words >= CALM_FROM) && (sent_words < CALM_TO);

    task automatic reset_meter_model();
        for (int p = 0; p < 3; p++) begin
            cfg_gain[p] = '0;
            ovf_cnt[p]  = '0;
            start_t[p]  = '0;
            armed[p]    = 1'b0;
            period[p]   = '0;
            residue[p]  = '0;
            energy[p]   = '0;
        end
        cfg_step      = ppem_pkg::RST_STEP;
        cfg_interval  = ppem_pkg::RST_INTERVAL;
        cfg_limit     = ppem_pkg::RST_LIMIT;
        cfg_main_span = ppem_pkg::RST_SPAN;
        cfg_aux_span  = ppem_pkg::RST_SPAN;
        tick_cnt      = '0;
    endtask

    function automatic void age_phase(int p);
        if (ovf_cnt[p] < cfg_limit) begin
            ovf_cnt[p] = ovf_cnt[p] + 8'd1;
        end else begin
            period[p] = '0;
            armed[p]  = 1'b0;
        end
    endfunction

    function automatic t_meter_word meter_predict(logic [1:0] op, logic [1:0] ph,
                                                  logic [15:0] cap);
        t_meter_word w;
        logic [31:0] span;
        w.fresh = 1'b0;
        case (op)
            ppem_pkg::OP_MAIN_TICK: begin
                if (tick_cnt > cfg_interval) begin
                    for (int p = 0; p < 3; p++) begin
                        if (period[p] != 0) begin
                            residue[p] = residue[p] + cfg_gain[p] / period[p];
                            if (residue[p] >= cfg_step) begin
                                energy[p]  = energy[p] + 32'd1;
                                residue[p] = residue[p] - cfg_step;
                            end
                        end
                    end
                    tick_cnt = '0;
                end
                age_phase(0);
                age_phase(1);
                tick_cnt = tick_cnt + 8'd1;
            end
            ppem_pkg::OP_AUX_TICK: begin
                age_phase(2);
            end
            ppem_pkg::OP_CAPTURE: begin
                if (ph != PHASE_OOR) begin
                    span = (ph == 2'd2) ? {15'd0, cfg_aux_span} : {15'd0, cfg_main_span};
                    if (armed[ph]) begin
                        period[ph] = span * {24'd0, ovf_cnt[ph]} - {16'd0, start_t[ph]}
                                     + {16'd0, cap};
                        w.fresh = 1'b1;
                    end
                    start_t[ph] = cap;
                    ovf_cnt[ph] = '0;
                    armed[ph]   = 1'b1;
                end
            end
            default: begin
            end
        endcase
        for (int p = 0; p < 3; p++) begin
            w.fields[p]     = period[p];
            w.fields[3 + p] = energy[p];
        end
        return w;
    endfunction

    task automatic cfg_write(input logic [ppem_pkg::CFG_ADDR_W-1:0] addr,
                             input logic [31:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_data <= data;
        case (addr)
            ppem_pkg::CFG_GAIN_0:    cfg_gain[0]   = data;
            ppem_pkg::CFG_GAIN_1:    cfg_gain[1]   = data;
            ppem_pkg::CFG_GAIN_2:    cfg_gain[2]   = data;
            ppem_pkg::CFG_STEP:      cfg_step      = data;
            ppem_pkg::CFG_INTERVAL:  cfg_interval  = data[7:0];
            ppem_pkg::CFG_LIMIT:     cfg_limit     = data[7:0];
            ppem_pkg::CFG_MAIN_SPAN: cfg_main_span = data[16:0];
            ppem_pkg::CFG_AUX_SPAN:  cfg_aux_span  = data[16:0];
            default: begin
            end
        endcase
        @(negedge i_clk);
    endtask

    task automatic apply_settings(input logic [31:0] g0, g1, g2, step, interval, limit,
                                  main_span, aux_span);
        cfg_write(ppem_pkg::CFG_GAIN_0, g0);
        cfg_write(ppem_pkg::CFG_GAIN_1, g1);
        cfg_write(ppem_pkg::CFG_GAIN_2, g2);
        cfg_write(ppem_pkg::CFG_STEP, step);
        cfg_write(ppem_pkg::CFG_INTERVAL, interval);
        cfg_write(ppem_pkg::CFG_LIMIT, limit);
        cfg_write(ppem_pkg::CFG_MAIN_SPAN, main_span);
        cfg_write(ppem_pkg::CFG_AUX_SPAN, aux_span);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic send_word(input logic [1:0] op, input logic [1:0] ph, input logic [15:0] cap,
                             input logic typed, input t_meter_word typed_word);
        t_meter_word w;
        while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= {ph, op};
        s_axis_tdata  <= cap;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        w = meter_predict(op, ph, cap);
        expected_meter_q.push_back(typed ? typed_word : w);
        sent_words++;
        if (op == ppem_pkg::OP_MAIN_TICK) n_main++;
        else if (op == ppem_pkg::OP_AUX_TICK) n_aux++;
        else if (op == ppem_pkg::OP_CAPTURE && ph != PHASE_OOR) n_capture++;
        else n_ignored++;
        @(negedge i_clk);
    endtask

    task automatic random_word();
        int          r;
        logic [1:0]  op;
        logic [1:0]  ph;
        logic [15:0] cap;
        r   = $urandom_range(0, 99);
        cap = 16'($urandom);
        ph  = 2'($urandom_range(0, 3));
        if (r < 40) begin
            op = ppem_pkg::OP_MAIN_TICK;
        end else if (r < 58) begin
            op = ppem_pkg::OP_AUX_TICK;
        end else if (r < 94) begin
            op = ppem_pkg::OP_CAPTURE;
            ph = 2'($urandom_range(0, 2));
        end else if (r < 97) begin
            op = OP_UNUSED;
        end else begin
            op = ppem_pkg::OP_CAPTURE;
            ph = PHASE_OOR;
        end
        send_word(op, ph, cap, 1'b0, '0);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (expected_meter_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
            $display("mismatch on %s at word %0d: expected %h, got %h",
                     what, checked_words, want, got);
    endtask

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d words outstanding",
                     cycle_cnt, expected_meter_q.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // receiver: random stalls, one quiet stretch, one long hold-off
    always @(negedge i_clk) begin
        if (hold_left < 0 && sent_words >= HOLD_AT)
            hold_left = HOLD_CYCLES;
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_meter_q.size() == 0) begin
                report("word with nothing expected", '0, m_axis_tdata[31:0]);
            end else begin
                want_word = expected_meter_q.pop_front();
                for (int f = 0; f < 6; f++) begin
                    if (m_axis_tdata[32*f +: 32] !== want_word.fields[f])
                        report(field_names[f], want_word.fields[f], m_axis_tdata[32*f +: 32]);
                end
                if (m_axis_tuser[0] !== want_word.fresh)
                    report("new_period", {31'd0, want_word.fresh}, {31'd0, m_axis_tuser[0]});
            end
            if (m_axis_tuser[0] === 1'b1)
                fresh_seen++;
            checked_words++;
        end
    end

    initial begin
        t_meter_word tw;
        t_dir_row    row;
        reset_meter_model();
        // register defaults; typed rows follow by hand from span 65536
        dir_rows.push_back('{ppem_pkg::OP_MAIN_TICK, 2'd0, 16'h0000, 1'b1,
                             32'd0, 32'd0, 32'd0, 1'b0});
        dir_rows.push_back('{ppem_pkg::OP_AUX_TICK, 2'd0, 16'h0000, 1'b1,
                             32'd0, 32'd0, 32'd0, 1'b0});
        dir_rows.push_back('{OP_UNUSED, PHASE_OOR, 16'hFFFF, 1'b1, 32'd0, 32'd0, 32'd0, 1'b0});
        dir_rows.push_back('{ppem_pkg::OP_CAPTURE, PHASE_OOR, 16'h1234, 1'b1,
                             32'd0, 32'd0, 32'd0, 1'b0});
        dir_rows.push_back('{ppem_pkg::OP_CAPTURE, 2'd0, 16'h0000, 1'b1,
                             32'd0, 32'd0, 32'd0, 1'b0});
        dir_rows.push_back('{ppem_pkg::OP_CAPTURE, 2'd0, 16'hFFFF, 1'b1,
                             32'd65535, 32'd0, 32'd0, 1'b1});
        dir_rows.push_back('{ppem_pkg::OP_CAPTURE, 2'd1, 16'hFFFF, 1'b1,
                             32'd65535, 32'd0, 32'd0, 1'b0});
        dir_rows.push_back('{ppem_pkg::OP_MAIN_TICK, 2'd3, 16'hFFFF, 1'b1,
                             32'd65535, 32'd0, 32'd0, 1'b0});
        dir_rows.push_back('{ppem_pkg::OP_CAPTURE, 2'd1, 16'h0000, 1'b1,
                             32'd65535, 32'd1, 32'd0, 1'b1});
        dir_rows.push_back('{ppem_pkg::OP_CAPTURE, 2'd2, 16'h8000, 1'b1,
                             32'd65535, 32'd1, 32'd0, 1'b0});
        dir_rows.push_back('{ppem_pkg::OP_AUX_TICK, 2'd2, 16'h0000, 1'b1,
                             32'd65535, 32'd1, 32'd0, 1'b0});
        dir_rows.push_back('{ppem_pkg::OP_AUX_TICK, 2'd1, 16'hFFFF, 1'b1,
                             32'd65535, 32'd1, 32'd0, 1'b0});
        dir_rows.push_back('{ppem_pkg::OP_CAPTURE, 2'd2, 16'h8000, 1'b1,
                             32'd65535, 32'd1, 32'd131072, 1'b1});
        // wrapped period, unused opcode with live state, ticks short of accumulation
        dir_rows.push_back('{ppem_pkg::OP_CAPTURE, 2'd0, 16'h0000, 1'b0,
                             32'd0, 32'd0, 32'd0, 1'b0});
        dir_rows.push_back('{OP_UNUSED, 2'd1, 16'h5555, 1'b0, 32'd0, 32'd0, 32'd0, 1'b0});
        dir_rows.push_back('{ppem_pkg::OP_CAPTURE, 2'd1, 16'h5555, 1'b0,
                             32'd0, 32'd0, 32'd0, 1'b0});
        dir_rows.push_back('{ppem_pkg::OP_CAPTURE, 2'd2, 16'hAAAA, 1'b0,
                             32'd0, 32'd0, 32'd0, 1'b0});
        for (int i = 0; i < 8; i++)
            dir_rows.push_back('{ppem_pkg::OP_MAIN_TICK, 2'(i), 16'(i * 16'h1111), 1'b0,
                                 32'd0, 32'd0, 32'd0, 1'b0});

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[i]) begin
            row          = dir_rows[i];
            tw.fresh     = row.fresh;
            tw.fields    = '0;
            tw.fields[0] = row.pa;
            tw.fields[1] = row.pb;
            tw.fields[2] = row.pc;
            send_word(row.op, row.ph, row.cap, row.typed, tw);
        end
        drain();

        for (int s = 0; s < SETTING_SETS; s++) begin
            case (s)
                0: apply_settings($urandom, $urandom, $urandom, 32'd1000, 32'd10, 32'd50,
                                  32'h10000, 32'h10000);
                1: apply_settings(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'd1, 32'd0,
                                  32'd0, 32'd1, 32'd1);
                2: apply_settings($urandom, $urandom, $urandom, 32'hFFFFFFFF, 32'd255,
                                  32'd255, 32'h10000, 32'h10000);
                3: apply_settings($urandom, $urandom, $urandom, 32'd0, 32'd2, 32'd8,
                                  32'd0, 32'h0001FFFF);
                4: apply_settings($urandom, $urandom, $urandom,
                                  $urandom_range(1, 32'h100000),
                                  ($urandom & 32'hFFFFFF00) | $urandom_range(0, 5),
                                  ($urandom & 32'hFFFFFF00) | $urandom_range(1, 20),
                                  ($urandom & 32'hFFFE0000) | $urandom_range(1, 65536),
                                  ($urandom & 32'hFFFE0000) | $urandom_range(1, 65536));
                default: apply_settings(32'd0, 32'd0, $urandom, 32'd1, 32'd254, 32'd255,
                                        32'h10000, 32'd1);
            endcase
            repeat (RAND_PER_SET) random_word();
            drain();
        end

        $display("%0d words checked over %0d register settings: %0d captures, %0d main ticks,",
                 checked_words, SETTING_SETS + 1, n_capture, n_main);
        $display("%0d aux ticks, %0d ignored words, %0d new periods, %0d mismatches",
                 n_aux, n_ignored, fresh_seen, mismatch_cnt);
        if (mismatch_cnt == 0 && expected_meter_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
